[hw/rtl/sqk_pkg.sv]
package sqk_pkg;

    localparam int CompWidth  = 16;
    localparam int FloatWidth = 32;
    localparam int Lanes      = 4;
    localparam int CountWidth = 3;
    localparam int StatWidth  = 2;

    localparam logic [FloatWidth-1:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [14:0]           DIVISOR   = 15'd32767;
    localparam logic [CountWidth-1:0] COUNT_MAX = 3'd7;

    localparam logic [StatWidth-1:0] STAT_OK    = 2'd0;
    localparam logic [StatWidth-1:0] STAT_LONG  = 2'd1;
    localparam logic [StatWidth-1:0] STAT_SHORT = 2'd2;

    localparam logic [15:0] INTERP_TRI_A = 16'd2;
    localparam logic [15:0] INTERP_TRI_B = 16'd3;

    typedef struct packed {
        logic [StatWidth-1:0] status;
        logic                 last;
    } key_info_t;

endpackage

[hw/rtl/sqk_lane.sv]
module sqk_lane
(
    input  logic signed [sqk_pkg::CompWidth-1:0] comp,
    output logic [sqk_pkg::FloatWidth-1:0]       fval
);

    logic signed [16:0] e;
    logic [14:0] m;
    logic [14:0] mn;
    logic [3:0]  lz;
    logic [23:0] y;
    logic [8:0]  a;
    logic [15:0] sum;
    logic        c;
    logic [15:0] r;
    logic        rnd;
    logic [23:0] q;
    logic [7:0]  expo;
    logic        sgn;

    always_comb
    begin
        if (comp > 16'sd0)
            e = 17'(comp) - 17'sd32767;
        else
            e = 17'(comp) + 17'sd32767;
        sgn = e[16];
        m   = sgn ? 15'(-e) : e[14:0];
    end

    // leading zero count over the 15-bit magnitude
    always_comb
    begin
        lz = 4'd0;
        for (int i = 0; i < 15; i++)
        begin
            if (m[i])
                lz = 4'(14 - i);
        end
    end

    // x*2^24/(2^15-1) = x*2^9 + x*2^9/(2^15-1), folded once
    always_comb
    begin
        mn   = m << lz;
        y    = {mn, 9'b0};
        a    = y[23:15];
        sum  = 16'(a) + 16'(y[14:0]);
        c    = sum >= 16'(sqk_pkg::DIVISOR);
        r    = c ? sum - 16'(sqk_pkg::DIVISOR) : sum;
        rnd  = r >= 16'd16384;
        q    = y + 24'(a) + 24'(c) + 24'(rnd);
        expo = 8'd126 - 8'(lz);
    end

    always_comb
    begin
        if (comp == -16'sd1)
            fval = sqk_pkg::ONE_BITS;
        else if (m == 15'd0)
            fval = '0;
        else if (m == sqk_pkg::DIVISOR)
            fval = {sgn, sqk_pkg::ONE_BITS[30:0]};
        else
            fval = {sgn, expo, q[22:0]};
    end

endmodule

[hw/rtl/sqk_key_track.sv]
module sqk_key_track
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     beat,
    input  logic                     key_end,
    input  logic [15:0]              interp_type,
    output sqk_pkg::key_info_t       info
);

    logic [sqk_pkg::CountWidth-1:0] count_reg;
    logic [sqk_pkg::CountWidth-1:0] count_next;
    logic [3:0] pos;
    logic [3:0] mult;

    always_comb
    begin
        mult = (interp_type == sqk_pkg::INTERP_TRI_A || interp_type == sqk_pkg::INTERP_TRI_B)
             ? 4'd3 : 4'd1;
        pos  = 4'(count_reg) + 4'd1;
        info.last = key_end;
        if (pos > mult)
            info.status = sqk_pkg::STAT_LONG;
        else if (key_end && pos < mult)
            info.status = sqk_pkg::STAT_SHORT;
        else
            info.status = sqk_pkg::STAT_OK;

        if (key_end)
            count_next = '0;
        else if (pos > 4'(sqk_pkg::COUNT_MAX))
            count_next = sqk_pkg::COUNT_MAX;
        else
            count_next = pos[sqk_pkg::CountWidth-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (beat)
            count_reg <= count_next;
    end

endmodule

[hw/rtl/snorm16_quaternion_key_to_float_core.sv]
// Decodes one compressed quaternion per beat: four snorm16 components become IEEE singles
// through four decode lanes side by side, and a key counter adds the key length status.
// Each beat passes through the lanes into the output register, and its result is valid in
// the cycle after. One beat per cycle; s_tready is low only while a result waits.
module snorm16_quaternion_key_to_float_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // comp_x, comp_y, comp_z, comp_w
    input  logic         s_tlast,   // key_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // float_x, float_y, float_z, float_w
    output logic         m_tlast,   // key_last
    output logic [1:0]   m_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] ADDR_INTERP = 3'd0;

    logic [15:0]  interp_reg;
    logic         beat;
    logic [127:0] lane_out;
    sqk_pkg::key_info_t info;
    logic         valid_reg;
    logic [127:0] data_reg;
    logic         last_reg;
    logic [1:0]   stat_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_INTERP) ? {{16{interp_reg[15]}}, interp_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            interp_reg <= '0;
        else if (psel && penable && pwrite && paddr == ADDR_INTERP)
            interp_reg <= pwdata[15:0];
    end

    assign s_tready = !valid_reg || m_tready;
    assign beat     = s_tvalid && s_tready;

    genvar g;
    generate
        for (g = 0; g < sqk_pkg::Lanes; g++)
        begin : g_lane
            sqk_lane u_lane
            (
                .comp (s_tdata[16*g +: 16]),
                .fval (lane_out[32*g +: 32])
            );
        end
    endgenerate

    sqk_key_track u_track
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .key_end     (s_tlast),
        .interp_type (interp_reg),
        .info        (info)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            data_reg <= lane_out;
            last_reg <= info.last;
            stat_reg <= info.status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = stat_reg;

endmodule

[hw/rtl/sqk_checker.sv]
module sqk_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tlast,
    input logic [1:0]   m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat dropped or changed under stall");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

    a_short_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == 2'd2 |-> m_tlast)
        else $error("short key status without key end");

    a_follow: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

endmodule

bind snorm16_quaternion_key_to_float_core sqk_checker u_sqk_checker (.*);

[test/snorm16_quaternion_key_to_float_core_test.sv]
`timescale 1ns / 1ps

module snorm16_quaternion_key_to_float_core_test;

    localparam logic [2:0] ADDR_INTERP = 3'd0;

    typedef struct {
        logic [127:0]                  floats;
        logic                          last;
        logic [sqk_pkg::StatWidth-1:0] status;
    } quat_result_t;

    class quat_scoreboard;
        quat_result_t                   pending[$];
        int                             errors = 0;
        logic signed [15:0]             interp = 16'sd0;
        logic [sqk_pkg::CountWidth-1:0] key_count = '0;

        function automatic logic [31:0] snorm_to_single(logic signed [15:0] v);
            int    e;
            int    mag;
            int    sh;
            longint num;
            longint q;
            longint r;
            logic [31:0] sgn;
            if (v == -16'sd1)
                return sqk_pkg::ONE_BITS;
            e = (v > 0) ? int'(v) - 32767 : int'(v) + 32767;
            sgn = (e < 0) ? 32'h8000_0000 : 32'h0;
            mag = (e < 0) ? -e : e;
            if (mag == 0)
                return 32'h0;
            if (mag >= 32767)
                return sgn | sqk_pkg::ONE_BITS;
            // normalise so that the quotient carries 24 significant bits
            sh = 23;
            while (sh < 40 && ((longint'(mag) << sh) / 32767) < (64'd1 << 23))
                sh++;
            num = longint'(mag) << sh;
            q = num / 32767;
            r = num % 32767;
            if (2 * r > 32767)
                q++;
            if (q >= (64'd1 << 24))
            begin
                q = q >>> 1;
                sh--;
            end
            return sgn | (32'(150 - sh) << 23) | (32'(q) & 32'h7F_FFFF);
        endfunction

        function void note_quat(logic [63:0] comps, logic key_end);
            quat_result_t res;
            int per_key;
            int pos;
            per_key = (interp == 16'(sqk_pkg::INTERP_TRI_A) ||
                       interp == 16'(sqk_pkg::INTERP_TRI_B)) ? 3 : 1;
            pos = int'(key_count) + 1;
            for (int i = 0; i < sqk_pkg::Lanes; i++)
                res.floats[32*i +: 32] = snorm_to_single(comps[16*i +: 16]);
            res.last = key_end;
            if (pos > per_key)
                res.status = sqk_pkg::STAT_LONG;
            else if (key_end && pos < per_key)
                res.status = sqk_pkg::STAT_SHORT;
            else
                res.status = sqk_pkg::STAT_OK;
            pending.insert(pending.size(), res);
            if (key_end)
                key_count = '0;
            else if (pos > int'(sqk_pkg::COUNT_MAX))
                key_count = sqk_pkg::COUNT_MAX;
            else
                key_count = pos[sqk_pkg::CountWidth-1:0];
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [127:0] floats, logic last, logic [1:0] status);
            quat_result_t exp_res;
            if (pending.size() == 0)
            begin
                report("result beat with nothing expected");
                return;
            end
            exp_res = pending.pop_front();
            for (int i = 0; i < sqk_pkg::Lanes; i++)
                if (floats[32*i +: 32] !== exp_res.floats[32*i +: 32])
                    report($sformatf("lane %0d got %h want %h", i,
                                     floats[32*i +: 32], exp_res.floats[32*i +: 32]));
            if (last !== exp_res.last)
                report($sformatf("key_last got %b want %b", last, exp_res.last));
            if (status !== exp_res.status)
                report($sformatf("status got %0d want %0d", status, exp_res.status));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tlast;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    quat_scoreboard scb = new();
    bit  use_gaps = 1'b1;
    int  burst_left = 0;
    int  stall_pct = 30;
    int  hold_cycles = 0;

    snorm16_quaternion_key_to_float_core u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // inputs only move at rising edges, so the falling edge sees what the next edge takes
    always @(negedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            scb.note_quat(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            scb.check_result(m_tdata, m_tlast, m_tuser);
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task send_quat(logic [63:0] comps, logic key_end);
        bit taken;
        if (use_gaps && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= comps;
        s_tlast <= key_end;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task drain_and_set(logic signed [15:0] interp);
        s_tvalid <= 1'b0;
        while (scb.pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        write_reg(ADDR_INTERP, 32'(interp));
        scb.interp = interp;
    endtask

    function automatic logic [15:0] rand_comp();
        logic [15:0] picks[6] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE};
        if ($urandom_range(9) == 0)
            return picks[$urandom_range(5)];
        return 16'($urandom);
    endfunction

    task random_keys(int count);
        int per_key;
        int key_len;
        int sent;
        per_key = (scb.interp == 16'(sqk_pkg::INTERP_TRI_A) ||
                   scb.interp == 16'(sqk_pkg::INTERP_TRI_B)) ? 3 : 1;
        sent = 0;
        while (sent < count)
        begin
            key_len = ($urandom_range(7) == 0) ? $urandom_range(1, 10) : per_key;
            for (int k = 0; k < key_len; k++)
            begin
                send_quat({rand_comp(), rand_comp(), rand_comp(), rand_comp()},
                          k == key_len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [15:0] edge_vals[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                                      16'h8000, 16'h3FFF, 16'hFFFE, 16'h0002};
        // proper key, short keys, a nine long key past saturation, a long key
        logic [19:0] ends = 20'b1000_0100_0000_0010_1100;
        logic signed [15:0] modes[8] = '{16'sd0, 16'sd3, -16'sd32768, 16'sd32767,
                                         16'sd1, 16'sd2, -16'sd1, 16'sd3};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drain_and_set(16'sd2);
        for (int i = 0; i < 20; i++)
            send_quat({edge_vals[(i + 5) % 8], edge_vals[(i + 2) % 8],
                       edge_vals[(i + 1) % 8], edge_vals[i % 8]}, ends[i]);
        random_keys(150);

        for (int p = 0; p < 8; p++)
        begin
            // sender waits for every result before the register changes
            drain_and_set(modes[p]);
            use_gaps = (p % 3 != 1);
            stall_pct = (p == 2) ? 0 : 10 * (p % 5) + 10;
            if (p == 4)
                hold_cycles = 200;
            random_keys(155);
        end

        s_tvalid <= 1'b0;
        while (scb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (scb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
